### rtl/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg: shared types and calendar helpers
// Operation codes, sequencer states, month/year length lookups.
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

    typedef enum logic [1:0] {
        OP_LOAD       = 2'd0,
        OP_ADD_DAYS   = 2'd1,
        OP_ADD_MONTHS = 2'd2,
        OP_ADD_YEARS  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_YEARS,
        S_MONTHS,
        S_MADJ,
        S_MCARRY,
        S_FINISH
    } state_t;

    localparam logic [4:0]  DefaultDay   = 5'd1;
    localparam logic [3:0]  DefaultMonth = 4'd1;
    localparam logic [13:0] DefaultYear  = 14'd1970;
    localparam logic [3:0]  MonthsPerYr  = 4'd12;

    // reciprocal of 12 for 15-bit dividends: q = (n * DivRecip) >> DivShift
    localparam logic [15:0] DivRecip = 16'd43691;
    localparam int          DivShift = 19;

    // leap rule: divisible by four, so only the two low bits matter
    function automatic logic is_leap(input logic [1:0] ylo);
        return (ylo == 2'b00);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] year_len(input logic leap);
        return leap ? 9'd366 : 9'd365;
    endfunction

endpackage

`default_nettype wire

### rtl/cda_sub_unit.sv
// ----------------------------------------------------------------------------
// cda_sub_unit: shared compare/subtract
// Reports a > b and gives a - b; the one arithmetic unit of the day walk.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_sub_unit (
    input  wire logic [15:0] a,
    input  wire logic [8:0]  b,
    output logic [15:0]      diff,
    output logic             gt
);

    logic [16:0] full;

    assign full = {1'b0, a} - {8'b0, b};
    assign diff = full[15:0];
    // no borrow and nonzero
    assign gt   = !full[16] && (full[15:0] != 16'd0);

endmodule

`default_nettype wire

### rtl/cda_div12.sv
// ----------------------------------------------------------------------------
// cda_div12: divide by twelve
// Registered reciprocal multiply; remainder formed after the register.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_div12 (
    input  wire logic        clk,
    input  wire logic [14:0] n,
    output logic [11:0]      quot,
    output logic [3:0]       rem
);

    import cda_pkg::*;

    logic [30:0] prod;
    logic [11:0] quot_reg;
    logic [14:0] n_reg;
    logic [14:0] q12;

    assign prod = 31'({16'b0, n} * {15'b0, DivRecip});

    always_ff @(posedge clk)
    begin
        quot_reg <= prod[DivShift+11:DivShift];
        n_reg    <= n;
    end

    // q * 12 = q * 8 + q * 4
    assign q12  = {quot_reg, 3'b000} + {1'b0, quot_reg, 2'b00};
    assign quot = quot_reg;
    assign rem  = 4'(n_reg - q12);

endmodule

`default_nettype wire

### rtl/calendar_date_adder_unit.sv
// ----------------------------------------------------------------------------
// calendar_date_adder_unit: calendar date keeper with add operations
// Holds one date; each input beat loads it or adds days, months or years.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel op_valid/op_stall carries one operation per beat
//   (load, add days, add months, add years) with amount and load fields.
//   Output channel res_valid/res_stall returns exactly one beat per
//   operation: the current date after it, and error when it was rejected
//   (bad load date, negative amount, year past MAX_YEAR). A rejected
//   operation leaves the date as it was.
//   One operation is processed at a time; op_stall is high from accept
//   until the result is written into the output register.
//   Load, add years, zero or negative amounts go from decode straight
//   to the result; add months passes an adjust step and, unless the
//   year overflows, a month carry step. Add days walks first a whole
//   year per cycle, then a month per cycle, through one shared
//   compare/subtract unit.
//   Reset puts the date at 1 January 1970 and empties the output register.
//   If the receiver stalls, the result waits in the output register and a
//   new operation can still be accepted; a finished operation then waits
//   for the register to drain before committing.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_adder_unit #(
    parameter int MAX_YEAR = 9999
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // operation channel
    input  wire logic               op_valid,
    output logic                    op_stall,
    input  wire logic [1:0]         operation,
    input  wire logic signed [15:0] amount,
    input  wire logic [4:0]         load_day,
    input  wire logic [3:0]         load_month,
    input  wire logic [13:0]        load_year,
    // result channel
    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic [4:0]              day,
    output logic [3:0]              month,
    output logic [13:0]             year,
    output logic                    error
);

    import cda_pkg::*;

    localparam logic [15:0] MaxYear = 16'(MAX_YEAR);

    state_t state_reg, state_next;

    // current date
    logic [4:0]  cur_day_reg, cur_day_next;
    logic [3:0]  cur_month_reg, cur_month_next;
    logic [13:0] cur_year_reg, cur_year_next;

    // latched operation beat
    logic [1:0]  op_reg;
    logic [15:0] amount_reg;
    logic [4:0]  ld_day_reg;
    logic [3:0]  ld_month_reg;
    logic [13:0] ld_year_reg;

    // working date
    logic [15:0] wd_reg, wd_next;
    logic [3:0]  wm_reg, wm_next;
    logic [15:0] wy_reg, wy_next;
    logic        werr_reg, werr_next;

    // output register
    logic        res_valid_reg, res_valid_next;
    logic [4:0]  day_reg, day_next;
    logic [3:0]  month_reg, month_next;
    logic [13:0] year_reg, year_next;
    logic        error_reg, error_next;

    logic        accept;
    logic [8:0]  sub_b;
    logic [15:0] sub_diff;
    logic        sub_gt;
    logic [11:0] div_q;
    logic [3:0]  div_r;

    // decode helpers
    logic [4:0]  ld_d;
    logic [3:0]  ld_m;
    logic [13:0] ld_y;
    logic        ld_ok;
    logic [15:0] ysum;
    logic [15:0] wy_p1;
    logic        yr_leap;
    logic [4:0]  madj_m;
    logic [4:0]  madj_mw;
    logic        madj_c;
    logic [15:0] madj_y;

    assign accept = op_valid && !op_stall;

    cda_sub_unit u_sub (
        .a    (wd_reg),
        .b    (sub_b),
        .diff (sub_diff),
        .gt   (sub_gt)
    );

    cda_div12 u_div (
        .clk  (clk),
        .n    (amount_reg[14:0]),
        .quot (div_q),
        .rem  (div_r)
    );

    // load defaults and validity
    assign ld_d  = (ld_day_reg == 5'd0) ? DefaultDay : ld_day_reg;
    assign ld_m  = (ld_month_reg == 4'd0) ? DefaultMonth : ld_month_reg;
    assign ld_y  = (ld_year_reg == 14'd0) ? DefaultYear : ld_year_reg;
    assign ld_ok = (ld_m <= MonthsPerYr) && ({2'b00, ld_y} <= MaxYear)
                   && (ld_d <= month_len(ld_m, is_leap(ld_y[1:0])));

    assign ysum  = {2'b00, cur_year_reg} + {1'b0, amount_reg[14:0]};
    assign wy_p1 = wy_reg + 16'd1;

    // twelve months from (wm, wy) hold the February of wy when wm is
    // January or February, else that of the next year
    assign yr_leap = (wm_reg <= 4'd2) ? is_leap(wy_reg[1:0]) : is_leap(wy_p1[1:0]);

    // month add: month plus remainder, wrap into next year
    assign madj_m  = {1'b0, cur_month_reg} + {1'b0, div_r};
    assign madj_c  = (madj_m > {1'b0, MonthsPerYr});
    assign madj_mw = madj_c ? (madj_m - {1'b0, MonthsPerYr}) : madj_m;
    assign madj_y  = {2'b00, cur_year_reg} + {4'b0, div_q} + {15'b0, madj_c};

    // shared unit operand
    always_comb
    begin
        case (state_reg)
            S_YEARS: sub_b = year_len(yr_leap);
            default: sub_b = {4'b0, month_len(wm_reg, is_leap(wy_reg[1:0]))};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_day_reg   <= DefaultDay;
            cur_month_reg <= DefaultMonth;
            cur_year_reg  <= DefaultYear;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_day_reg   <= cur_day_next;
            cur_month_reg <= cur_month_next;
            cur_year_reg  <= cur_year_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= operation;
            amount_reg   <= amount;
            ld_day_reg   <= load_day;
            ld_month_reg <= load_month;
            ld_year_reg  <= load_year;
        end
        wd_reg    <= wd_next;
        wm_reg    <= wm_next;
        wy_reg    <= wy_next;
        werr_reg  <= werr_next;
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        error_reg <= error_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_day_next   = cur_day_reg;
        cur_month_next = cur_month_reg;
        cur_year_next  = cur_year_reg;
        wd_next        = wd_reg;
        wm_next        = wm_reg;
        wy_next        = wy_reg;
        werr_next      = werr_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        error_next     = error_reg;
        res_valid_next = res_valid_reg && res_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                wd_next    = {11'b0, cur_day_reg};
                wm_next    = cur_month_reg;
                wy_next    = {2'b00, cur_year_reg};
                werr_next  = 1'b0;
                state_next = S_FINISH;
                if (op_t'(op_reg) == OP_LOAD)
                begin
                    werr_next = !ld_ok;
                    wd_next   = {11'b0, ld_d};
                    wm_next   = ld_m;
                    wy_next   = {2'b00, ld_y};
                end
                else if (amount_reg[15])
                begin
                    werr_next = 1'b1;
                end
                else if (amount_reg != 16'd0)
                begin
                    case (op_t'(op_reg))
                        OP_ADD_DAYS:
                        begin
                            wd_next    = {11'b0, cur_day_reg} + amount_reg;
                            state_next = S_YEARS;
                        end
                        OP_ADD_MONTHS:
                        begin
                            // the divider registers quotient and dividend this cycle
                            state_next = S_MADJ;
                        end
                        default:
                        begin
                            wy_next   = ysum;
                            werr_next = (ysum > MaxYear);
                            // February 29 in a common year becomes March 1
                            if (cur_day_reg == 5'd29 && cur_month_reg == 4'd2
                                && !is_leap(ysum[1:0]))
                            begin
                                wd_next = 16'd1;
                                wm_next = 4'd3;
                            end
                        end
                    endcase
                end
            end

            S_YEARS:
            begin
                if (sub_gt)
                begin
                    wd_next = sub_diff;
                    wy_next = wy_p1;
                    if (wy_p1 > MaxYear)
                    begin
                        werr_next  = 1'b1;
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    state_next = S_MONTHS;
                end
            end

            S_MONTHS:
            begin
                if (sub_gt)
                begin
                    wd_next = sub_diff;
                    if (wm_reg == MonthsPerYr)
                    begin
                        wm_next = 4'd1;
                        wy_next = wy_p1;
                        if (wy_p1 > MaxYear)
                        begin
                            werr_next  = 1'b1;
                            state_next = S_FINISH;
                        end
                    end
                    else
                    begin
                        wm_next = wm_reg + 4'd1;
                    end
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_MADJ:
            begin
                wm_next   = madj_mw[3:0];
                wy_next   = madj_y;
                werr_next = (madj_y > MaxYear);
                state_next = (madj_y > MaxYear) ? S_FINISH : S_MCARRY;
            end

            S_MCARRY:
            begin
                // day past the month end spills into the next month
                if (sub_gt)
                begin
                    wd_next = sub_diff;
                    wm_next = wm_reg + 4'd1;
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    error_next     = werr_reg;
                    if (werr_reg)
                    begin
                        day_next   = cur_day_reg;
                        month_next = cur_month_reg;
                        year_next  = cur_year_reg;
                    end
                    else
                    begin
                        day_next       = wd_reg[4:0];
                        month_next     = wm_reg;
                        year_next      = wy_reg[13:0];
                        cur_day_next   = wd_reg[4:0];
                        cur_month_next = wm_reg;
                        cur_year_next  = wy_reg[13:0];
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign op_stall  = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign day       = day_reg;
    assign month     = month_reg;
    assign year      = year_reg;
    assign error     = error_reg;

endmodule

`default_nettype wire

### tb/tb_calendar_date_adder_unit.sv
// ----------------------------------------------------------------------------
// tb_calendar_date_adder_unit: self-checking bench for the calendar date adder
// Sends load / add-days / add-months / add-years beats through the operation
// channel and keeps its own calendar model of the current date. Each result
// beat is compared field by field with the oldest predicted date. Both sides
// idle and stall at random, and the receiver once holds off long enough for
// the block to back up its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_calendar_date_adder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cda_pkg::*;

    localparam int MaxYear        = 9999;
    localparam int RandomOps      = 1125;
    localparam int LongHoldAt     = 300;   // result count at which the sink holds off
    localparam int LongHoldCycles = 400;
    localparam int DrainCycles    = 150;   // outlasts the longest add-days walk

    // one predicted result beat
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic        error;
    } date_beat_t;

    // ------------------------------------------------------------------------
    // Calendar scoreboard: tracks the date the block should hold, queues the
    // beat each accepted operation should produce, and checks result beats.
    // ------------------------------------------------------------------------
    class date_scoreboard;
        logic [4:0]  cur_day;
        logic [3:0]  cur_month;
        logic [13:0] cur_year;
        date_beat_t  pending_dates[$];
        int          failures;
        int          checked;
        int          rejected;
        int          op_count[4];

        function new();
            cur_day   = DefaultDay;
            cur_month = DefaultMonth;
            cur_year  = DefaultYear;
            failures  = 0;
            checked   = 0;
            rejected  = 0;
            foreach (op_count[i]) op_count[i] = 0;
        endfunction

        // leap years are simply the multiples of four here
        function int unsigned days_in(int unsigned m, int unsigned y);
            if (m == 2) return (y % 4 == 0) ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
            return 31;
        endfunction

        // carries out one operation on the tracked date; 0 means rejected
        function bit advance_date(op_t op, logic signed [15:0] amt, logic [4:0] ld,
                                  logic [3:0] lm, logic [13:0] ly);
            int unsigned d, m, y, n, len;
            d = cur_day;
            m = cur_month;
            y = cur_year;
            n = {16'b0, amt};
            if (op == OP_LOAD) begin
                d = (ld == 0) ? 1 : ld;
                m = (lm == 0) ? 1 : lm;
                y = (ly == 0) ? 1970 : ly;
                if (m > 12 || y > MaxYear) return 1'b0;
                if (d > days_in(m, y)) return 1'b0;
            end
            else if (amt[15]) begin
                return 1'b0;
            end
            else if (n != 0) begin
                case (op)
                    OP_ADD_DAYS: begin
                        d += n;
                        while (d > days_in(m, y)) begin
                            d -= days_in(m, y);
                            m++;
                            if (m > 12) begin
                                m = 1;
                                y++;
                                if (y > MaxYear) return 1'b0;
                            end
                        end
                    end
                    OP_ADD_MONTHS: begin
                        m += n % 12;
                        y += n / 12;
                        if (m > 12) begin
                            m -= 12;
                            y++;
                        end
                        if (y > MaxYear) return 1'b0;
                        // day past month end spills into the following month
                        len = days_in(m, y);
                        if (d > len) begin
                            d -= len;
                            m++;
                        end
                    end
                    default: begin
                        y += n;
                        if (y > MaxYear) return 1'b0;
                        if (d == 29 && m == 2 && (y % 4) != 0) begin
                            d = 1;
                            m = 3;
                        end
                    end
                endcase
            end
            cur_day   = d[4:0];
            cur_month = m[3:0];
            cur_year  = y[13:0];
            return 1'b1;
        endfunction

        function void note_op(op_t op, logic signed [15:0] amt, logic [4:0] ld,
                              logic [3:0] lm, logic [13:0] ly);
            date_beat_t beat;
            bit ok;
            ok = advance_date(op, amt, ld, lm, ly);
            beat.day   = cur_day;
            beat.month = cur_month;
            beat.year  = cur_year;
            beat.error = !ok;
            pending_dates.push_back(beat);
            op_count[op]++;
            if (!ok) rejected++;
        endfunction

        function void check_result(logic [4:0] d, logic [3:0] m, logic [13:0] y, logic e);
            date_beat_t want;
            if (pending_dates.size() == 0) begin
                $error("result beat with nothing pending: %0d/%0d/%0d error=%0b", d, m, y, e);
                failures++;
                return;
            end
            want = pending_dates.pop_front();
            checked++;
            if (d !== want.day) begin
                $error("day: expected %0d, actual %0d", want.day, d);
                failures++;
            end
            if (m !== want.month) begin
                $error("month: expected %0d, actual %0d", want.month, m);
                failures++;
            end
            if (y !== want.year) begin
                $error("year: expected %0d, actual %0d", want.year, y);
                failures++;
            end
            if (e !== want.error) begin
                $error("error: expected %0b, actual %0b", want.error, e);
                failures++;
            end
        endfunction

        function int pending();
            return pending_dates.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic               clk = 1'b0;
    logic               rst_n;
    logic               op_valid;
    logic               op_stall;
    logic [1:0]         operation;
    logic signed [15:0] amount;
    logic [4:0]         load_day;
    logic [3:0]         load_month;
    logic [13:0]        load_year;
    logic               res_valid;
    logic               res_stall;
    logic [4:0]         day;
    logic [3:0]         month;
    logic [13:0]        year;
    logic               error;

    date_scoreboard sb;
    int             sent = 0;

    calendar_date_adder_unit #(
        .MAX_YEAR(MaxYear)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .operation (operation),
        .amount    (amount),
        .load_day  (load_day),
        .load_month(load_month),
        .load_year (load_year),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .day       (day),
        .month     (month),
        .year      (year),
        .error     (error)
    );

    always #4 clk = ~clk;

    // Random idle wait before a beat, except for one stretch in every
    // four where the side runs flat out.
    function automatic int draw_wait(int idx);
        if ((idx / 90) % 4 == 2) return 0;
        return $urandom_range(0, 18);
    endfunction

    // Offer one operation beat and hold it until the block takes it.
    // op_valid stays high when the next beat follows back to back, so it is
    // only lowered when a gap is actually drawn.
    task automatic send_op(input op_t op, input logic signed [15:0] amt,
                           input logic [4:0] ld, input logic [3:0] lm, input logic [13:0] ly);
        int gap;
        gap = draw_wait(sent);
        if (gap > 0) begin
            op_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op_valid   <= 1'b1;
        operation  <= op;
        amount     <= amt;
        load_day   <= ld;
        load_month <= lm;
        load_year  <= ly;
        @(posedge clk);
        while (op_stall !== 1'b0) @(posedge clk);
        sb.note_op(op, amt, ld, lm, ly);
        sent++;
    endtask

    // Add amount: mostly modest positive counts, with zero, the full
    // positive range and negative values mixed in.
    function automatic logic signed [15:0] pick_amount(int unsigned modest_max);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return 16'h8000 | 16'($urandom_range(0, 32767));
        if (r <= 4) return 16'($urandom_range(0, 32767));
        return 16'($urandom_range(1, modest_max));
    endfunction

    // One random operation. Fields the operation ignores carry junk.
    task automatic send_random_op();
        op_t                op;
        logic signed [15:0] amt;
        logic [4:0]         ld;
        logic [3:0]         lm;
        logic [13:0]        ly;
        int unsigned        sel, r, yy, mm, len;
        amt = 16'($urandom);
        ld  = 5'($urandom);
        lm  = 4'($urandom);
        ly  = 14'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
            op = OP_LOAD;
            r  = $urandom_range(0, 9);
            if (r == 0) begin
                // raw fields over their whole width, mostly invalid
                ld = 5'($urandom_range(0, 31));
                lm = 4'($urandom_range(0, 15));
                ly = 14'($urandom_range(0, 16383));
            end
            else if (r == 1) begin
                // some fields left at zero to pick up the defaults
                ld = ($urandom_range(0, 1) != 0) ? 5'd0 : 5'($urandom_range(1, 28));
                lm = ($urandom_range(0, 1) != 0) ? 4'd0 : 4'($urandom_range(1, 12));
                ly = ($urandom_range(0, 1) != 0) ? 14'd0 : 14'($urandom_range(1, 9999));
            end
            else begin
                // well-formed date; near the top year now and then so that
                // adds run into the overflow
                yy  = (r == 2) ? $urandom_range(9900, 9999)
                    : (r < 6)  ? $urandom_range(1900, 2100) : $urandom_range(1, 9999);
                mm  = $urandom_range(1, 12);
                len = sb.days_in(mm, yy);
                ld  = 5'($urandom_range(1, len));
                // occasionally one day past the end of the month
                if (len < 31 && $urandom_range(0, 7) == 0) ld = 5'(len + 1);
                lm  = 4'(mm);
                ly  = 14'(yy);
            end
        end
        else if (sel < 55) begin
            op  = OP_ADD_DAYS;
            amt = pick_amount(400);
        end
        else if (sel < 78) begin
            op  = OP_ADD_MONTHS;
            amt = pick_amount(40);
        end
        else begin
            op  = OP_ADD_YEARS;
            amt = pick_amount(30);
        end
        send_op(op, amt, ld, lm, ly);
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random stall before each beat, plus one long hold-off so
    // the output register fills and the block pushes back on its input.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold;
        res_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            hold = (sb.checked == LongHoldAt) ? LongHoldCycles : draw_wait(sb.checked);
            if (hold > 0) begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            @(posedge clk);
            while (res_valid !== 1'b1) @(posedge clk);
            sb.check_result(day, month, year, error);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        sb = new();
        rst_n      <= 1'b0;
        op_valid   <= 1'b0;
        operation  <= OP_LOAD;
        amount     <= '0;
        load_day   <= '0;
        load_month <= '0;
        load_year  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corner cases, starting from the reset date.
        send_op(OP_ADD_DAYS,   16'sd0,      5'd0,  4'd0,  14'd0);     // zero amount
        send_op(OP_ADD_DAYS,   -16'sd1,     5'd0,  4'd0,  14'd0);     // negative
        send_op(OP_ADD_MONTHS, 16'sh8000,   5'd0,  4'd0,  14'd0);     // most negative
        send_op(OP_ADD_YEARS,  -16'sd1,     5'd0,  4'd0,  14'd0);
        send_op(OP_LOAD,       16'sd0,      5'd0,  4'd0,  14'd0);     // all defaults
        send_op(OP_LOAD,       16'sd0,      5'd31, 4'd0,  14'd0);     // Jan 31 1970
        send_op(OP_LOAD,       16'sd0,      5'd29, 4'd2,  14'd2024);  // leap day
        send_op(OP_ADD_YEARS,  16'sd1,      5'd0,  4'd0,  14'd0);     // Feb 29 -> Mar 1
        send_op(OP_LOAD,       16'sd0,      5'd29, 4'd2,  14'd2023);  // no leap day
        send_op(OP_LOAD,       16'sd0,      5'd31, 4'd4,  14'd2000);  // 30-day month
        send_op(OP_LOAD,       16'sd0,      5'd1,  4'd15, 14'd2000);  // month out of range
        send_op(OP_LOAD,       16'sd0,      5'd1,  4'd1,  14'd16383); // year out of range
        send_op(OP_LOAD,       16'sd0,      5'd31, 4'd12, 14'd9999);  // last date
        send_op(OP_ADD_DAYS,   16'sd1,      5'd0,  4'd0,  14'd0);     // year overflow
        send_op(OP_ADD_MONTHS, 16'sd1,      5'd0,  4'd0,  14'd0);
        send_op(OP_ADD_YEARS,  16'sd1,      5'd0,  4'd0,  14'd0);
        send_op(OP_ADD_YEARS,  16'sd0,      5'd0,  4'd0,  14'd0);
        send_op(OP_LOAD,       16'sd0,      5'd31, 4'd1,  14'd2024);
        send_op(OP_ADD_MONTHS, 16'sd1,      5'd0,  4'd0,  14'd0);     // carry, leap Feb
        send_op(OP_LOAD,       16'sd0,      5'd31, 4'd1,  14'd2023);
        send_op(OP_ADD_MONTHS, 16'sd1,      5'd0,  4'd0,  14'd0);     // carry, plain Feb
        send_op(OP_LOAD,       16'sd0,      5'd31, 4'd10, 14'd2000);
        send_op(OP_ADD_MONTHS, 16'sd1,      5'd0,  4'd0,  14'd0);     // Nov 31 -> Dec 1
        send_op(OP_LOAD,       16'sd0,      5'd1,  4'd1,  14'd1);
        send_op(OP_ADD_DAYS,   16'sh7FFF,   5'd0,  4'd0,  14'd0);     // longest walk
        send_op(OP_ADD_MONTHS, 16'sh7FFF,   5'd0,  4'd0,  14'd0);
        send_op(OP_ADD_YEARS,  16'sh7FFF,   5'd0,  4'd0,  14'd0);     // overflow

        repeat (RandomOps) send_random_op();
        op_valid <= 1'b0;

        // let the last results drain, then watch for stray beats
        while (sb.pending() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("Run covered %0d operations: %0d loads, %0d day, %0d month, %0d year adds",
                 sent, sb.op_count[OP_LOAD], sb.op_count[OP_ADD_DAYS],
                 sb.op_count[OP_ADD_MONTHS], sb.op_count[OP_ADD_YEARS]);
        $display("%0d result beats checked, %0d of them flagged as rejected",
                 sb.checked, sb.rejected);
        if (sb.failures == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: several times the slowest legal run (every beat with full
    // idle on both sides plus the longest add-days walk).
    initial begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
